// ===== rtl/core/position_pid_with_integral_zone_assert.svh =====
// Assertion helpers for the RTL of the position PID block.
`ifndef POSITION_PID_WITH_INTEGRAL_ZONE_ASSERT_SVH
`define POSITION_PID_WITH_INTEGRAL_ZONE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDZ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidz: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIDZ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidz: next-cycle check failed");

`endif

// ===== rtl/core/pidz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pidz_pkg;

    // Default parameter values
    localparam int DEF_POS_WIDTH      = 16;
    localparam int DEF_GAIN_FRAC_BITS = 8;

    // Fixed field widths
    localparam int GAIN_W          = 16;
    localparam int ZONE_W          = 15;
    localparam int LIMIT_W         = 16;
    localparam int SCALE_W         = 17;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int DRIVE_W         = 8;
    localparam int CFG_IDX_W       = 3;

    // Constants of the control law
    localparam int DRIVE_MAX = 127;
    localparam int DEAD_BAND = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd6;

    // Register reset values
    localparam logic [GAIN_W-1:0]         KP_RST    = 16'd3584;
    localparam logic [GAIN_W-1:0]         KD_RST    = 16'd15360;
    localparam logic [GAIN_W-1:0]         KI_RST    = 16'd256;
    localparam logic [ZONE_W-1:0]         ZONE_RST  = 15'd100;
    localparam logic [LIMIT_W-1:0]        LIMIT_RST = 16'd2000;
    localparam logic signed [SCALE_W-1:0] SCALE_RST = -17'sd4951;

    // Loop settings handed from the register file to the sequencer
    typedef struct packed {
        logic [GAIN_W-1:0]         prop_gain;
        logic [GAIN_W-1:0]         deriv_gain;
        logic [GAIN_W-1:0]         integ_gain;
        logic [ZONE_W-1:0]         integ_zone;
        logic [LIMIT_W-1:0]        integ_limit;
        logic signed [SCALE_W-1:0] output_scale;
    } t_gains;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pidz_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pidz_cfg #(
    parameter int POS_WIDTH = pidz_pkg::DEF_POS_WIDTH
) (
    input  wire logic                                                i_clk,
    input  wire logic                                                i_rst_n,
    input  wire logic                                                i_valid,
    output logic                                                     o_ready,
    input  wire logic [pidz_pkg::CFG_IDX_W-1:0]                      i_index,
    input  wire logic [pidz_pkg::imax(POS_WIDTH, pidz_pkg::SCALE_W)-1:0] i_data,
    output logic signed [POS_WIDTH-1:0]                              o_target,
    output pidz_pkg::t_gains                                         o_gains
);

    logic signed [POS_WIDTH-1:0] r_target;
    pidz_pkg::t_gains            r_gains;

    // Write decode, one register per beat; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target             <= '0;
            r_gains.prop_gain    <= pidz_pkg::KP_RST;
            r_gains.deriv_gain   <= pidz_pkg::KD_RST;
            r_gains.integ_gain   <= pidz_pkg::KI_RST;
            r_gains.integ_zone   <= pidz_pkg::ZONE_RST;
            r_gains.integ_limit  <= pidz_pkg::LIMIT_RST;
            r_gains.output_scale <= pidz_pkg::SCALE_RST;
        end else if (i_valid) begin
            unique case (i_index)
                pidz_pkg::REG_TARGET: r_target <= i_data[POS_WIDTH-1:0];
                pidz_pkg::REG_KP:     r_gains.prop_gain <= i_data[pidz_pkg::GAIN_W-1:0];
                pidz_pkg::REG_KD:     r_gains.deriv_gain <= i_data[pidz_pkg::GAIN_W-1:0];
                pidz_pkg::REG_KI:     r_gains.integ_gain <= i_data[pidz_pkg::GAIN_W-1:0];
                pidz_pkg::REG_ZONE:   r_gains.integ_zone <= i_data[pidz_pkg::ZONE_W-1:0];
                pidz_pkg::REG_LIMIT:  r_gains.integ_limit <= i_data[pidz_pkg::LIMIT_W-1:0];
                pidz_pkg::REG_SCALE:  r_gains.output_scale <= i_data[pidz_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_ready  = 1'b1;
    assign o_target = r_target;
    assign o_gains  = r_gains;

endmodule

`default_nettype wire

// ===== rtl/core/pidz_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pidz_mul #(
    parameter int A_W = pidz_pkg::GAIN_W + 4,
    parameter int B_W = pidz_pkg::DEF_POS_WIDTH + 2
) (
    input  wire logic                  i_clk,
    input  wire logic signed [A_W-1:0] i_a,
    input  wire logic signed [B_W-1:0] i_b,
    output logic signed [A_W+B_W-1:0]  o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    // Shared signed multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== rtl/core/pidz_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "position_pid_with_integral_zone_assert.svh"

module pidz_seq #(
    parameter int POS_WIDTH      = pidz_pkg::DEF_POS_WIDTH,
    parameter int GAIN_FRAC_BITS = pidz_pkg::DEF_GAIN_FRAC_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic signed [POS_WIDTH-1:0]          i_target,
    input  wire pidz_pkg::t_gains                     i_gains,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [POS_WIDTH-1:0]          i_pos,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [pidz_pkg::DRIVE_W-1:0]       o_drive
);

    // Datapath widths
    localparam int ERR_W   = POS_WIDTH + 1;
    localparam int DER_W   = POS_WIDTH + 2;
    localparam int ACC_W   = pidz_pkg::imax(ERR_W, pidz_pkg::LIMIT_W + 1) + 1;
    localparam int CMP_W   = pidz_pkg::imax(ERR_W, pidz_pkg::ZONE_W);
    localparam int SUM_W   = ACC_W + pidz_pkg::GAIN_W + 3;
    localparam int LO_W    = (SUM_W + 1) / 2;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int MA_W    = pidz_pkg::imax(pidz_pkg::GAIN_W + 1,
                                            pidz_pkg::imax(LO_W + 1, HI_W));
    localparam int MB_W    = ACC_W;
    localparam int PROD_W  = SUM_W + pidz_pkg::SCALE_W;
    localparam int SHIFT   = GAIN_FRAC_BITS + pidz_pkg::SCALE_FRAC_BITS;
    localparam int Q_W     = PROD_W - SHIFT;
    localparam int DRIVE_W = pidz_pkg::DRIVE_W;

    localparam logic [CMP_W-1:0]        DEAD  = CMP_W'(pidz_pkg::DEAD_BAND);
    localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(pidz_pkg::DRIVE_MAX);
    localparam logic signed [Q_W-1:0]   Q_MIN = -Q_W'(pidz_pkg::DRIVE_MAX);
    localparam logic [PROD_W-1:0]       BIAS  = {{(PROD_W-SHIFT){1'b0}}, {SHIFT{1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE, S_LAW, S_CLAMP, S_MD, S_MI, S_SUM, S_MLO, S_MHI, S_CMB, S_TRUNC, S_SAT
    } t_state;

    t_state                     r_state,     n_state;
    logic signed [ERR_W-1:0]    r_err,       n_err;
    logic signed [ERR_W-1:0]    r_prev,      n_prev;
    logic signed [DER_W-1:0]    r_der,       n_der;
    logic signed [ACC_W-1:0]    r_acc,       n_acc;
    logic signed [ACC_W-1:0]    r_acc_raw,   n_acc_raw;
    logic                       r_in_zone,   n_in_zone;
    logic signed [SUM_W-1:0]    r_sum,       n_sum;
    logic signed [PROD_W-1:0]   r_prod,      n_prod;
    logic signed [Q_W-1:0]      r_q,         n_q;
    logic                       r_out_valid, n_out_valid;
    logic signed [DRIVE_W-1:0]  r_drive,     n_drive;

    logic [ERR_W-1:0]           w_aerr;
    logic                       w_zone_ok;
    logic signed [ACC_W-1:0]    w_lim;
    logic signed [ACC_W-1:0]    w_acc_clamp;
    logic [PROD_W-1:0]          w_round;
    logic signed [DRIVE_W-1:0]  w_sat;
    logic signed [MA_W-1:0]     w_mul_a;
    logic signed [MB_W-1:0]     w_mul_b;
    logic signed [MA_W+MB_W-1:0] w_mul_p;

    // Shared multiplier
    pidz_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // Error magnitude and integral zone test (zone open, dead band closed)
    always_comb begin
        w_aerr    = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
        w_zone_ok = (CMP_W'(w_aerr) < CMP_W'(i_gains.integ_zone)) &&
                    (CMP_W'(w_aerr) > DEAD);
    end

    // Symmetric clamp of the integral
    always_comb begin
        w_lim = ACC_W'(i_gains.integ_limit);
        if (r_acc_raw > w_lim) begin
            w_acc_clamp = w_lim;
        end else if (r_acc_raw < -w_lim) begin
            w_acc_clamp = -w_lim;
        end else begin
            w_acc_clamp = r_acc_raw;
        end
    end

    // Truncate toward zero, then saturate the drive
    always_comb begin
        w_round = r_prod + (r_prod[PROD_W-1] ? BIAS : '0);
        if (r_q > Q_MAX) begin
            w_sat = DRIVE_W'(pidz_pkg::DRIVE_MAX);
        end else if (r_q < Q_MIN) begin
            w_sat = -DRIVE_W'(pidz_pkg::DRIVE_MAX);
        end else begin
            w_sat = r_q[DRIVE_W-1:0];
        end
    end

    // Sequencer: next state, multiplier operands, datapath updates
    always_comb begin
        n_state     = r_state;
        n_err       = r_err;
        n_prev      = r_prev;
        n_der       = r_der;
        n_acc       = r_acc;
        n_acc_raw   = r_acc_raw;
        n_in_zone   = r_in_zone;
        n_sum       = r_sum;
        n_prod      = r_prod;
        n_q         = r_q;
        n_drive     = r_drive;
        n_out_valid = r_out_valid;
        w_mul_a     = MA_W'(i_gains.prop_gain);
        w_mul_b     = MB_W'(r_err);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_err   = ERR_W'(i_target) - ERR_W'(i_pos);
                    n_state = S_LAW;
                end
            end
            S_LAW: begin
                n_der     = (r_err != '0) ? (DER_W'(r_err) - DER_W'(r_prev)) : '0;
                n_acc_raw = r_acc + ACC_W'(r_err);
                n_in_zone = w_zone_ok;
                n_prev    = r_err;
                n_state   = S_CLAMP;
            end
            S_CLAMP: begin
                n_acc   = r_in_zone ? w_acc_clamp : '0;
                w_mul_a = MA_W'(i_gains.prop_gain);
                w_mul_b = MB_W'(r_err);
                n_state = S_MD;
            end
            S_MD: begin
                n_sum   = SUM_W'(w_mul_p);
                w_mul_a = MA_W'(i_gains.deriv_gain);
                w_mul_b = MB_W'(r_der);
                n_state = S_MI;
            end
            S_MI: begin
                n_sum   = r_sum + SUM_W'(w_mul_p);
                w_mul_a = MA_W'(i_gains.integ_gain);
                w_mul_b = MB_W'(r_acc);
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum   = r_sum + SUM_W'(w_mul_p);
                n_state = S_MLO;
            end
            S_MLO: begin
                // low half of the sum, unsigned
                w_mul_a = MA_W'(r_sum[LO_W-1:0]);
                w_mul_b = MB_W'(i_gains.output_scale);
                n_state = S_MHI;
            end
            S_MHI: begin
                n_prod  = PROD_W'(w_mul_p);
                // high half of the sum, signed
                w_mul_a = MA_W'($signed(r_sum[SUM_W-1:LO_W]));
                w_mul_b = MB_W'(i_gains.output_scale);
                n_state = S_CMB;
            end
            S_CMB: begin
                n_prod  = r_prod + (PROD_W'(w_mul_p) <<< LO_W);
                n_state = S_TRUNC;
            end
            S_TRUNC: begin
                n_q     = w_round[PROD_W-1:SHIFT];
                n_state = S_SAT;
            end
            S_SAT: begin
                // hold here while the previous beat is still unread
                if (!r_out_valid || i_out_ready) begin
                    n_drive     = w_sat;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_acc       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_prev      <= n_prev;
            r_acc       <= n_acc;
        end
        r_err     <= n_err;
        r_der     <= n_der;
        r_acc_raw <= n_acc_raw;
        r_in_zone <= n_in_zone;
        r_sum     <= n_sum;
        r_prod    <= n_prod;
        r_q       <= n_q;
        r_drive   <= n_drive;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

    // Checks
    `PIDZ_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_LAW)
    `PIDZ_ASSERT_IMP(a_acc_in_limit, i_clk, i_rst_n, r_state == S_MD, (r_acc <= w_lim) && (r_acc >= -w_lim))
    `PIDZ_ASSERT_NXT(a_zone_clears, i_clk, i_rst_n, (r_state == S_CLAMP) && !r_in_zone, r_acc == '0)
    `PIDZ_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, (r_state == S_SAT) && r_out_valid && !i_out_ready, r_state == S_SAT)
    `PIDZ_ASSERT_IMP(a_drive_sat, i_clk, i_rst_n, r_out_valid, !r_drive[DRIVE_W-1] || (r_drive[DRIVE_W-2:0] != '0))

endmodule

`default_nettype wire

// ===== rtl/core/position_pid_with_integral_zone.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Position PID with integral zone.
// Input stream (s_axis): one encoder position sample per beat. Output stream
// (m_axis): one signed drive command (-127..127) per input beat, in order.
// Config channel (i_cfg_*): register index and data, to be written by the user
// when the block is idle (the block itself does not enforce this); o_cfg_ready
// is always high. Indexes: 0 target, 1 kp, 2 kd, 3 ki, 4 integral zone,
// 5 integral limit, 6 output scale; others are ignored. An accepted sample
// steps through LAW, CLAMP, MD, MI, SUM, MLO, MHI, CMB, TRUNC and SAT; the
// block takes one sample at a time and walks it through a single shared
// multiplier under a sequencer (three gain products, then two half-width scale products).
// Stall: a finished drive sits in the output register and the next sample is
// still accepted; the following result waits in the last step until the
// earlier beat is taken.
// Reset (synchronous, active low): registers return to their defaults,
// previous error and integral accumulator clear, the output goes empty.
module position_pid_with_integral_zone #(
    parameter int POS_WIDTH      = pidz_pkg::DEF_POS_WIDTH,
    parameter int GAIN_FRAC_BITS = pidz_pkg::DEF_GAIN_FRAC_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // slave side: tdata = position
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  wire logic [((POS_WIDTH+7)/8)*8-1:0]         i_s_axis_tdata,
    // master side: tdata = drive
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    output logic [pidz_pkg::DRIVE_W-1:0]                o_m_axis_tdata,
    // configuration writes
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [pidz_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [pidz_pkg::imax(POS_WIDTH, pidz_pkg::SCALE_W)-1:0] i_cfg_data
);

    logic signed [POS_WIDTH-1:0]         w_target;
    pidz_pkg::t_gains                    w_gains;
    logic signed [pidz_pkg::DRIVE_W-1:0] w_drive;

    // Register file
    pidz_cfg #(
        .POS_WIDTH (POS_WIDTH)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_cfg_valid),
        .o_ready  (o_cfg_ready),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_target (w_target),
        .o_gains  (w_gains)
    );

    // Control law sequencer
    pidz_seq #(
        .POS_WIDTH      (POS_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_target    (w_target),
        .i_gains     (w_gains),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_pos       ($signed(i_s_axis_tdata[POS_WIDTH-1:0])),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_drive     (w_drive)
    );

    assign o_m_axis_tdata = w_drive;

endmodule

`default_nettype wire

// ===== dv/position_pid_with_integral_zone_tb.sv =====
`timescale 1ns / 1ps

// Drive predictor and in-order checker for the position PID block.
class pid_scoreboard;
    // register copies, decoded to plain integers
    longint target;
    longint kp;
    longint kd;
    longint ki;
    longint zone;
    longint limit;
    longint scale;
    // loop state
    longint prev_err;
    longint integ;
    // expected drive beats, oldest first
    logic [7:0] drive_q[$];
    int errors;

    function new();
        target   = 0;
        kp       = pidz_pkg::KP_RST;
        kd       = pidz_pkg::KD_RST;
        ki       = pidz_pkg::KI_RST;
        zone     = pidz_pkg::ZONE_RST;
        limit    = pidz_pkg::LIMIT_RST;
        scale    = pidz_pkg::SCALE_RST;
        prev_err = 0;
        integ    = 0;
        errors   = 0;
    endfunction

    function void write_reg(logic [pidz_pkg::CFG_IDX_W-1:0] idx, logic [16:0] data);
        case (idx)
            pidz_pkg::REG_TARGET: target = $signed(data[15:0]);
            pidz_pkg::REG_KP:     kp     = data[15:0];
            pidz_pkg::REG_KD:     kd     = data[15:0];
            pidz_pkg::REG_KI:     ki     = data[15:0];
            pidz_pkg::REG_ZONE:   zone   = data[14:0];
            pidz_pkg::REG_LIMIT:  limit  = data[15:0];
            pidz_pkg::REG_SCALE:  scale  = $signed(data);
            default: ;  // unmapped index, write dropped
        endcase
    endfunction

    // Runs one control step on an accepted position and queues its drive.
    function void note_sample(logic signed [15:0] pos);
        longint err;
        longint deriv;
        longint aerr;
        longint sum;
        longint prod;
        longint q;
        longint sum_max;
        err     = target - longint'(pos);
        deriv   = 0;
        aerr    = (err < 0) ? -err : err;
        sum_max = longint'(1) << 46;
        if (err != 0) begin
            deriv = err - prev_err;
        end else begin
            integ = 0;
        end
        // integrate only inside the zone; dead band clears it
        if (aerr < zone) begin
            integ = integ + err;
            if (aerr <= pidz_pkg::DEAD_BAND)
                integ = 0;
        end else begin
            integ = 0;
        end
        // symmetric clamp, sign kept
        if (integ > limit)
            integ = limit;
        else if (integ < -limit)
            integ = -limit;
        sum = kp * err + kd * deriv + ki * integ;
        if (sum > sum_max)
            sum = sum_max;
        else if (sum < -sum_max)
            sum = -sum_max;
        prod = sum * scale;
        // signed divide truncates toward zero
        q = prod / (longint'(1) << (pidz_pkg::DEF_GAIN_FRAC_BITS + pidz_pkg::SCALE_FRAC_BITS));
        if (q > pidz_pkg::DRIVE_MAX)
            q = pidz_pkg::DRIVE_MAX;
        else if (q < -pidz_pkg::DRIVE_MAX)
            q = -pidz_pkg::DRIVE_MAX;
        prev_err = err;
        drive_q.push_back(q[7:0]);
    endfunction

    function void check_drive(logic [7:0] got);
        logic [7:0] exp_drive;
        if (drive_q.size() == 0) begin
            $error("drive: expected none, actual %0d", $signed(got));
            errors++;
        end else begin
            exp_drive = drive_q.pop_front();
            if (got !== exp_drive) begin
                $error("drive: expected %0d, actual %0d", $signed(exp_drive), $signed(got));
                errors++;
            end
        end
    endfunction

    function int pending();
        return drive_q.size();
    endfunction
endclass

module position_pid_with_integral_zone_tb;

    localparam logic [pidz_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 75;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                           i_clk;
    logic                           rst_n     = 1'b0;
    logic                           s_valid   = 1'b0;
    logic [15:0]                    s_data    = '0;
    logic                           m_ready   = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [pidz_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [16:0]                    cfg_data  = '0;
    wire                            o_s_axis_tready;
    wire                            o_m_axis_tvalid;
    wire [pidz_pkg::DRIVE_W-1:0]    o_m_axis_tdata;
    wire                            o_cfg_ready;

    int send_pct = 0;
    int recv_pct = 0;
    int stall_cycles = 0;

    pid_scoreboard sb = new();

    position_pid_with_integral_zone i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // drive beats: check, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_ready)
            sb.check_drive(o_m_axis_tdata);
        m_ready <= ($urandom_range(0, 99) >= recv_pct);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)
                || (cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void set_idle(t_idle_mode mode);
        send_pct = (mode == IDLE_SEND) ? 56 : (mode == IDLE_BOTH) ? 9 : 0;
        recv_pct = (mode == IDLE_RECV) ? 56 : (mode == IDLE_BOTH) ? 9 : 0;
    endfunction

    // random value of up to n bits, with the width itself random
    function automatic int unsigned rand_bits(int n);
        return $urandom & ((32'd1 << $urandom_range(1, n)) - 1);
    endfunction

    // one position beat; valid stays high after the beat
    task automatic send_sample(logic [15:0] pos);
        while ($urandom_range(0, 99) < send_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= pos;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_sample(pos);
    endtask

    // one register beat; valid is lowered by the caller
    task automatic cfg_write(logic [pidz_pkg::CFG_IDX_W-1:0] idx, logic [16:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // stop sending and wait for every queued drive
    task automatic drain();
        s_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    task automatic load_settings(logic [16:0] target, logic [16:0] kp, logic [16:0] kd,
                                 logic [16:0] ki, logic [16:0] zone, logic [16:0] limit,
                                 logic [16:0] scale);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_write(pidz_pkg::REG_TARGET, target);
        cfg_write(pidz_pkg::REG_KP, kp);
        cfg_write(pidz_pkg::REG_KD, kd);
        cfg_write(pidz_pkg::REG_KI, ki);
        cfg_write(pidz_pkg::REG_ZONE, zone);
        cfg_write(pidz_pkg::REG_LIMIT, limit);
        cfg_write(pidz_pkg::REG_SCALE, scale);
        cfg_write(REG_UNUSED, 17'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int         offset;
        int         span;
        logic [15:0] pos;

        pos = '0;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, zero error, dead band, zone edges, extremes
        set_idle(IDLE_NONE);
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(-16'sd2);
        send_sample(16'd3);
        send_sample(16'd50);
        send_sample(16'd50);
        send_sample(-16'sd99);
        send_sample(16'd100);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'd0);

        // negative integral past the limit must clamp to -limit
        load_settings(17'd0, 17'd0, 17'd0, 17'hFFFF, 17'h7FFF, 17'd100, 17'hFFFF);
        send_sample(16'd60);
        send_sample(16'd60);
        send_sample(-16'sd60);
        send_sample(-16'sd60);
        send_sample(16'd0);

        // largest error and gains
        load_settings(17'h7FFF, 17'hFFFF, 17'hFFFF, 17'hFFFF, 17'h7FFF, 17'hFFFF, 17'h10000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFE);

        // zero scale forces zero drive
        load_settings(17'd0, 17'h1234, 17'h0800, 17'h0100, 17'd100, 17'd2000, 17'd0);
        send_sample(16'd5);
        send_sample(-16'sd5);

        // random phases, each with fresh settings and one of four idling patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 1)
                load_settings(17'h7FFF, 17'hFFFF, 17'hFFFF, 17'hFFFF, 17'h7FFF, 17'hFFFF,
                              17'hFFFF);
            else if (ph == 2)
                load_settings(17'h18000, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'h10000);
            else
                load_settings(17'($urandom), 17'(rand_bits(16)), 17'(rand_bits(16)),
                              17'(rand_bits(16)), 17'(rand_bits(15)), 17'(rand_bits(16)),
                              ($urandom_range(0, 1) ? 17'(rand_bits(16))
                                                    : -17'(rand_bits(16))));
            set_idle(t_idle_mode'(ph % 4));
            span   = int'(sb.zone) + 4;
            offset = $urandom_range(0, 2 * span) - span;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // mostly a drifting trajectory around the setpoint
                case ($urandom_range(0, 9))
                    0:       pos = 16'($urandom);
                    1:       offset = $urandom_range(0, 2 * span) - span;
                    2:       offset = $urandom_range(0, 6) - 3;
                    default: offset = offset + $urandom_range(0, 20) - 10;
                endcase
                if (n % 10 != 0 || $urandom_range(0, 1))
                    pos = 16'(sb.target - offset);
                send_sample(pos);
                // occasionally hold off until all drives are back
                if ($urandom_range(0, 99) < 3)
                    drain();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("drive: %0d expected beats never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
